// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KMI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmi assertion failed");

// next-cycle implication, disabled while reset is low
`define KMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmi assertion failed");

`endif

// ----- hw/rtl/kmi_pkg.sv -----
// ----------------------------------------------------------------------------
// kmi_pkg
// shared constants, codes and controller/datapath structs of the interpolator
// ----------------------------------------------------------------------------
package kmi_pkg;

	localparam int MAX_KEYS  = 256;
	localparam int KEY_W     = $clog2(MAX_KEYS);
	localparam int NK_W      = KEY_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(FRAC_BITS);
	localparam int TIME_W    = 32;
	localparam int ELAPSED_W = 16;
	localparam int VAL_W     = 32;
	localparam int ACT_W     = 2;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

	// item actions
	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BLEND = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

	// register select (paddr bit 2)
	localparam logic REG_NUM_KEYS = 1'b0;
	localparam logic REG_LOOP_EN  = 1'b1;

	localparam logic [NK_W-1:0] NUM_KEYS_RST = NK_W'(2);

	typedef struct packed {
		logic capture;   // latch the item fields
		logic load_key;  // write key timestamp
		logic tick_init; // clamp pointer, add elapsed time
		logic rd_next;   // read key at pointer + 1
		logic step;      // compare and maybe advance pointer
		logic rd_cur;    // read key at pointer
		logic setup;     // fraction special cases, divider start
		logic div_step;  // one quotient bit
		logic mul;       // blend multiply
		logic sum;       // blend add and saturate
		logic out_load;  // fill output register
	} kmi_cmd_t;

	typedef struct packed {
		logic past_next;  // time beyond next key timestamp
		logic div_needed; // fraction needs the divider
		logic div_last;   // final quotient bit this cycle
	} kmi_sts_t;

endpackage

// ----- hw/rtl/kmi_if.sv -----
// ----------------------------------------------------------------------------
// kmi item and result channels
// valid/ready channels carrying input items and result items
// ----------------------------------------------------------------------------
interface kmi_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [kmi_pkg::ACT_W-1:0]            action;
	logic [kmi_pkg::KEY_W-1:0]            key_index;
	logic [kmi_pkg::TIME_W-1:0]           key_time;
	logic [kmi_pkg::ELAPSED_W-1:0]        elapsed;
	logic signed [kmi_pkg::VAL_W-1:0]     base_value;
	logic signed [kmi_pkg::VAL_W-1:0]     delta_value;

	modport source (output valid, action, key_index, key_time, elapsed, base_value,
		delta_value, input ready);
	modport sink (input valid, action, key_index, key_time, elapsed, base_value,
		delta_value, output ready);
endinterface

interface kmi_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [kmi_pkg::KEY_W-1:0]            current_key;
	logic [kmi_pkg::FRAC_W-1:0]           fraction;
	logic                                 stopped;
	logic signed [kmi_pkg::VAL_W-1:0]     blended_value;

	modport source (output valid, current_key, fraction, stopped, blended_value,
		input ready);
	modport sink (input valid, current_key, fraction, stopped, blended_value,
		output ready);
endinterface

// ----- hw/rtl/kmi_ram.sv -----
// ----------------------------------------------------------------------------
// kmi_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kmi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/kmi_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmi_ctrl
// sequencer for load, tick and blend items; other actions go straight to the output state
// ----------------------------------------------------------------------------
module kmi_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [kmi_pkg::ACT_W-1:0] in_action,
	input  logic                      out_ready,
	input  kmi_pkg::kmi_sts_t         sts,
	output kmi_pkg::kmi_cmd_t         cmd,
	output logic                      in_ready,
	output logic                      out_valid
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_LOAD  = 11'b000_0000_0010,
		ST_TINIT = 11'b000_0000_0100,
		ST_RDN   = 11'b000_0000_1000,
		ST_CMP   = 11'b000_0001_0000,
		ST_RDC   = 11'b000_0010_0000,
		ST_SETUP = 11'b000_0100_0000,
		ST_DIV   = 11'b000_1000_0000,
		ST_MUL   = 11'b001_0000_0000,
		ST_SUM   = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} kmi_state_t;

	kmi_state_t state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_action)
						kmi_pkg::ACT_LOAD:  state_d = ST_LOAD;
						kmi_pkg::ACT_TICK:  state_d = ST_TINIT;
						kmi_pkg::ACT_BLEND: state_d = ST_MUL;
						default:            state_d = ST_OUT;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load_key = 1'b1;
				state_d      = ST_OUT;
			end
			ST_TINIT: begin
				cmd.tick_init = 1'b1;
				state_d       = ST_RDN;
			end
			ST_RDN: begin
				cmd.rd_next = 1'b1;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = sts.past_next ? ST_RDN : ST_RDC;
			end
			ST_RDC: begin
				cmd.rd_cur = 1'b1;
				state_d    = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.div_needed ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/kmi_dp.sv -----
// ----------------------------------------------------------------------------
// kmi_dp
// timeline state, key store, radix-2 divider, blend multiplier, result register
// ----------------------------------------------------------------------------
module kmi_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kmi_pkg::kmi_cmd_t                 cmd,
	output kmi_pkg::kmi_sts_t                 sts,
	input  logic [kmi_pkg::NK_W-1:0]          num_keys,
	input  logic                              loop_enable,
	input  logic [kmi_pkg::ACT_W-1:0]         in_action,
	input  logic [kmi_pkg::KEY_W-1:0]         in_key_index,
	input  logic [kmi_pkg::TIME_W-1:0]        in_key_time,
	input  logic [kmi_pkg::ELAPSED_W-1:0]     in_elapsed,
	input  logic signed [kmi_pkg::VAL_W-1:0]  in_base,
	input  logic signed [kmi_pkg::VAL_W-1:0]  in_delta,
	output logic [kmi_pkg::KEY_W-1:0]         current_key,
	output logic [kmi_pkg::FRAC_W-1:0]        fraction,
	output logic                              stopped,
	output logic signed [kmi_pkg::VAL_W-1:0]  blended_value
);

	localparam int PROD_W = kmi_pkg::VAL_W + kmi_pkg::FRAC_W + 1;
	localparam int Q_W    = PROD_W - kmi_pkg::FRAC_BITS;
	localparam int SUM_W  = Q_W + 1;
	localparam int TW     = kmi_pkg::TIME_W;
	localparam int KW     = kmi_pkg::KEY_W;
	localparam int NW     = kmi_pkg::NK_W;
	localparam int FW     = kmi_pkg::FRAC_W;
	localparam int VW     = kmi_pkg::VAL_W;

	// captured item
	logic [kmi_pkg::ACT_W-1:0]     action_q;
	logic [KW-1:0]                 key_index_q;
	logic [TW-1:0]                 key_time_q;
	logic [kmi_pkg::ELAPSED_W-1:0] elapsed_q;
	logic signed [VW-1:0]          base_q, delta_q;

	// timeline state
	logic [KW-1:0] ptr_q;
	logic [TW-1:0] time_q;
	logic          stop_q;
	logic [FW-1:0] frac_q;

	// divider
	logic [TW-1:0]                 t1_q, rem_q, den_q;
	logic [kmi_pkg::FRAC_BITS-1:0] quo_q;
	logic [kmi_pkg::CNT_W-1:0]     cnt_q;

	// blend
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [VW-1:0]     blend_s2;

	logic [TW-1:0] rd_data;

	// keys in use clamped to 2..MAX_KEYS
	logic [NW-1:0] n_keys;
	logic [KW-1:0] last_key, pen_key, ptr_inc;
	always_comb begin
		if (num_keys < NW'(2)) begin
			n_keys = NW'(2);
		end else if (num_keys > NW'(kmi_pkg::MAX_KEYS)) begin
			n_keys = NW'(kmi_pkg::MAX_KEYS);
		end else begin
			n_keys = num_keys;
		end
	end
	assign last_key = KW'(n_keys - NW'(1));
	assign pen_key  = KW'(n_keys - NW'(2));
	assign ptr_inc  = ptr_q + KW'(1);

	kmi_ram #(
		.WIDTH(TW),
		.DEPTH(kmi_pkg::MAX_KEYS)
	) u_keys (
		.clk   (clk),
		.we    (cmd.load_key),
		.waddr (key_index_q),
		.wdata (key_time_q),
		.re    (cmd.rd_next | cmd.rd_cur),
		.raddr (cmd.rd_next ? ptr_inc : ptr_q),
		.rdata (rd_data)
	);

	// saturating time add
	logic [TW:0] time_sum;
	assign time_sum = {1'b0, time_q} + (TW+1)'(elapsed_q);

	// fraction special cases, rd_data holds t0 in setup
	logic          frac_zero, frac_full;
	logic [TW-1:0] num_w, den_w;
	assign num_w     = time_q - rd_data;
	assign den_w     = t1_q - rd_data;
	assign frac_zero = stop_q || (t1_q <= rd_data) || (time_q <= rd_data);
	assign frac_full = (num_w >= den_w);

	// restoring division step
	logic [TW+1:0]                 trial;
	logic [kmi_pkg::FRAC_BITS-1:0] quo_next;
	assign trial    = {1'b0, rem_q, 1'b0} - {2'b00, den_q};
	assign quo_next = {quo_q[kmi_pkg::FRAC_BITS-2:0], ~trial[TW+1]};

	assign sts.past_next  = time_q > rd_data;
	assign sts.div_needed = !frac_zero && !frac_full;
	assign sts.div_last   = (cnt_q == kmi_pkg::CNT_W'(kmi_pkg::FRAC_BITS - 1));

	// floor shift and saturation of the blend sum
	logic signed [Q_W-1:0]   q_w;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [VW-1:0]    sat_w;
	assign q_w   = prod_s1[PROD_W-1:kmi_pkg::FRAC_BITS];
	assign sum_w = SUM_W'(base_q) + SUM_W'(q_w);
	always_comb begin
		if (sum_w > SUM_W'($signed({1'b0, {(VW-1){1'b1}}}))) begin
			sat_w = {1'b0, {(VW-1){1'b1}}};
		end else if (sum_w < SUM_W'($signed({1'b1, {(VW-1){1'b0}}}))) begin
			sat_w = {1'b1, {(VW-1){1'b0}}};
		end else begin
			sat_w = VW'(sum_w);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			time_q <= '0;
			stop_q <= 1'b0;
			frac_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.tick_init) begin
				if (ptr_q > pen_key) begin
					ptr_q <= pen_key;
				end
				time_q <= time_sum[TW] ? {TW{1'b1}} : time_sum[TW-1:0];
			end
			if (cmd.step && sts.past_next) begin
				if (ptr_inc == last_key) begin
					// end of timeline: wrap or hold and stop
					if (loop_enable) begin
						ptr_q <= '0;
					end else begin
						ptr_q  <= pen_key;
						stop_q <= 1'b1;
					end
					time_q <= '0;
				end else begin
					ptr_q <= ptr_inc;
				end
			end
			if (cmd.setup) begin
				cnt_q <= '0;
				if (frac_zero) begin
					frac_q <= '0;
				end else if (frac_full) begin
					frac_q <= kmi_pkg::FRAC_ONE;
				end
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + kmi_pkg::CNT_W'(1);
				if (sts.div_last) begin
					frac_q <= FW'(quo_next);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q    <= in_action;
			key_index_q <= in_key_index;
			key_time_q  <= in_key_time;
			elapsed_q   <= in_elapsed;
			base_q      <= in_base;
			delta_q     <= in_delta;
		end
		if (cmd.step) begin
			t1_q <= rd_data;
		end
		if (cmd.setup) begin
			rem_q <= num_w;
			den_q <= den_w;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial[TW+1] ? {rem_q[TW-2:0], 1'b0} : trial[TW-1:0];
			quo_q <= quo_next;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(delta_q) * PROD_W'($signed({1'b0, frac_q}));
		end
		if (cmd.sum) begin
			blend_s2 <= stop_q ? base_q : sat_w;
		end
		if (cmd.out_load) begin
			current_key   <= ptr_q;
			fraction      <= frac_q;
			stopped       <= stop_q;
			blended_value <= (action_q == kmi_pkg::ACT_BLEND) ? blend_s2 : '0;
		end
	end

endmodule

// ----- hw/rtl/keyframe_morph_interpolator_unit.sv -----
// the tick time is set by the key ram read loop, which has one read port, and the radix-2 divider
// one item in flight, next item taken in the cycle after the result register loads
// arst_n clears the timeline state and handshakes; num_keys resets to 2, loop_enable to 0
// the key timestamp ram has no reset and holds garbage until each key is loaded
// ----------------------------------------------------------------------------
// keyframe_morph_interpolator_unit
// morph timeline with keyed timestamps, fraction divider and linear blender
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyframe_morph_interpolator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	kmi_in_if.sink                      item,
	kmi_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kmi_pkg::APB_AW-1:0]  paddr,
	input  logic [kmi_pkg::APB_DW-1:0]  pwdata,
	output logic [kmi_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	kmi_pkg::kmi_cmd_t cmd;
	kmi_pkg::kmi_sts_t sts;

	// configuration registers
	logic [kmi_pkg::NK_W-1:0] num_keys_q;
	logic                     loop_enable_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// register select on paddr bit 2, low bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_keys_q    <= kmi_pkg::NUM_KEYS_RST;
			loop_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == kmi_pkg::REG_NUM_KEYS) begin
				num_keys_q <= pwdata[kmi_pkg::NK_W-1:0];
			end else begin
				loop_enable_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == kmi_pkg::REG_LOOP_EN) begin
			prdata = kmi_pkg::APB_DW'(loop_enable_q);
		end else begin
			prdata = kmi_pkg::APB_DW'(num_keys_q);
		end
	end

	// sequencer: one item at a time, result transfer through the output register
	kmi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (item.ready),
		.out_valid (result.valid)
	);

	// timeline, key store, divider and blender
	kmi_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.num_keys      (num_keys_q),
		.loop_enable   (loop_enable_q),
		.in_action     (item.action),
		.in_key_index  (item.key_index),
		.in_key_time   (item.key_time),
		.in_elapsed    (item.elapsed),
		.in_base       (item.base_value),
		.in_delta      (item.delta_value),
		.current_key   (result.current_key),
		.fraction      (result.fraction),
		.stopped       (result.stopped),
		.blended_value (result.blended_value)
	);

	// an accepted item makes the sequencer busy in the next cycle
	`KMI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready, !item.ready)
	// fraction never exceeds one
	`KMI_ASSERT_IMPLY(a_frac_range, clk, arst_n, result.valid, result.fraction <= kmi_pkg::FRAC_ONE)
	// a stopped timeline always reports a zero fraction
	`KMI_ASSERT_IMPLY(a_stop_frac, clk, arst_n, result.valid && result.stopped, result.fraction == '0)

endmodule
